@@ rtl/mgnp_pkg.sv @@
// Shared types and constants for the glyph row to nibble packer.
`timescale 1ns / 1ps
`default_nettype none
package mgnp_pkg;

    localparam int ROWS      = 64;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int MAX_WIDTH = 32;
    localparam int NIB_W     = 4;
    localparam int WORD_W    = 16;
    localparam int CELL_W    = 7;
    localparam int XPOS_W    = 8;
    localparam int GW_W      = 6;
    localparam int BITS_W    = 32;
    localparam int ALIGN_W   = BITS_W + NIB_W;
    localparam int SPAN_W    = 6;
    localparam int SHADOW_W  = CELL_W + WORD_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = NIB_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOUR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOUR = 1'b1;

    localparam logic [NIB_W-1:0] FG_RESET = 4'hF;
    localparam logic [NIB_W-1:0] BG_RESET = 4'h0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT
    } t_state;

    // Per-word control handed to the nibble unit.
    typedef struct packed {
        logic              first;
        logic [1:0]        xoff;
        logic [SPAN_W-1:0] left;
    } t_nib_ctl;

endpackage
`default_nettype wire

@@ rtl/mgnp_if.sv @@
// Handshake channel interfaces for glyph rows in and pixel words out.
`timescale 1ns / 1ps
`default_nettype none
interface mgnp_in_if;
    import mgnp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [XPOS_W-1:0]       x_pos;
    logic [ROW_W-1:0]        row_index;
    logic [GW_W-1:0]         glyph_len;
    logic [BITS_W-1:0]       row_bits;

    modport source (output valid, x_pos, row_index, glyph_len, row_bits, input ready);
    modport sink   (input valid, x_pos, row_index, glyph_len, row_bits, output ready);
endinterface

interface mgnp_out_if;
    import mgnp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [WORD_W-1:0]       pixel_word;
    logic                    last_word;

    modport source (output valid, pixel_word, last_word, input ready);
    modport sink   (input valid, pixel_word, last_word, output ready);
endinterface
`default_nettype wire

@@ rtl/mgnp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mgnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/mgnp_nibble_unit.sv @@
// Shared expander: builds one 4-pixel word from four glyph bits.
`timescale 1ns / 1ps
`default_nettype none
module mgnp_nibble_unit
    import mgnp_pkg::*;
(
    input  wire t_nib_ctl          i_ctl,
    input  wire logic [WORD_W-1:0] i_prev_word,
    input  wire logic [NIB_W-1:0]  i_bits,
    input  wire logic [NIB_W-1:0]  i_fg,
    input  wire logic [NIB_W-1:0]  i_bg,
    output logic      [WORD_W-1:0] o_word,
    output logic                   o_last
);

    always_comb begin
        o_word = '0;
        for (int k = 0; k < 4; k++) begin
            // Keep nibbles left of the start on the first cell; clear past the end.
            if (i_ctl.first && (2'(k) < i_ctl.xoff)) begin
                o_word[WORD_W-1-NIB_W*k -: NIB_W] = i_prev_word[WORD_W-1-NIB_W*k -: NIB_W];
            end else if (SPAN_W'(k) < i_ctl.left) begin
                o_word[WORD_W-1-NIB_W*k -: NIB_W] = i_bits[NIB_W-1-k] ? i_fg : i_bg;
            end
        end
        o_last = (i_ctl.left <= SPAN_W'(NIB_W));
    end

endmodule
`default_nettype wire

@@ rtl/mono_glyph_row_to_nibble_packer.sv @@
// Top level: glyph row to 4-bit gray nibble packer with per-row shadow.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Dir  Payload                                        Handshake
//  --------  ---  ---------------------------------------------  -----------
//  i_in      in   x_pos, row_index, glyph_len, row_bits          valid/ready
//  o_out     out  pixel_word, last_word                          valid/ready
//  i_cfg_*   in   index (0 fg_colour, 1 bg_colour), data [3:0]   write enable
//
//  An accepted row fetches its shadow entry in S_LOAD, then emits its words
//  through the shared nibble unit in S_EMIT, and input is ready again the
//  cycle after the last word is loaded into the output register. A row gives
//  ceil(span/4) words, span = min(width,32) + x_pos%4; an empty span gives none.
//  Reset (synchronous, active low) clears the sequencer, the output valid bit
//  and the 64 shadow valid bits, and holds off input; an invalid shadow row
//  reads as zero. A stalled output beat holds the sequencer in place.
//
module mono_glyph_row_to_nibble_packer
    import mgnp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    mgnp_in_if.sink                   i_in,
    mgnp_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_state                 r_state, n_state;
    logic [NIB_W-1:0]       r_fg, r_bg;
    logic [ROWS-1:0]        r_valid;

    // Row context captured on accept.
    logic [XPOS_W-1:0]      r_x;
    logic [ROW_W-1:0]       r_row;
    logic [SPAN_W-1:0]      r_left;
    logic [ALIGN_W-1:0]     r_bits;
    logic [CELL_W-1:0]      r_cell_end;
    logic [WORD_W-1:0]      r_word;
    logic                   r_first;

    // Output register.
    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_out_word;
    logic                   r_out_last;

    logic                   w_accept;
    logic                   w_slot_free;
    logic [NIB_W-1:0]       w_bg_eff;
    logic [GW_W-1:0]        w_width;
    logic [XPOS_W:0]        w_end_x;
    logic [SHADOW_W-1:0]    w_rdata;
    logic                   w_hit;
    logic [WORD_W-1:0]      w_init_word;
    t_nib_ctl               w_ctl;
    logic [WORD_W-1:0]      w_nib_word;
    logic                   w_nib_last;
    logic                   w_emit;
    logic                   w_load_init;
    logic                   w_shadow_we;
    logic [WORD_W-1:0]      w_shadow_word;

    assign i_in.ready   = (r_state == S_IDLE) & i_rst_n;
    assign w_accept     = i_in.valid & i_in.ready;
    assign w_slot_free  = ~r_out_valid | o_out.ready;
    assign w_bg_eff     = (r_fg == r_bg) ? '0 : r_bg;

    // Clamp the width and work out the cell that holds the end position x_pos + width.
    assign w_width = (i_in.glyph_len > GW_W'(MAX_WIDTH)) ? GW_W'(MAX_WIDTH)
                                                         : i_in.glyph_len;
    assign w_end_x = {1'b0, i_in.x_pos} + (XPOS_W+1)'(w_width);

    // Shadow store: {cell, pixels} per row.
    mgnp_ram #(
        .WIDTH (SHADOW_W),
        .DEPTH (ROWS)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (w_shadow_we),
        .i_waddr (r_row),
        .i_wdata ({r_cell_end, w_shadow_word}),
        .i_re    (w_accept),
        .i_raddr (i_in.row_index),
        .o_rdata (w_rdata)
    );

    // Reuse the stored word only when the row resumes in the stored cell.
    assign w_hit = r_valid[r_row] &&
                   (w_rdata[SHADOW_W-1 -: CELL_W] == CELL_W'(r_x[XPOS_W-1:2]));
    assign w_init_word = w_hit ? w_rdata[WORD_W-1:0] : '0;

    assign w_ctl.first = r_first;
    assign w_ctl.xoff  = r_x[1:0];
    assign w_ctl.left  = r_left;

    mgnp_nibble_unit u_nibble (
        .i_ctl       (w_ctl),
        .i_prev_word (r_word),
        .i_bits      (r_bits[ALIGN_W-1 -: NIB_W]),
        .i_fg        (r_fg),
        .i_bg        (w_bg_eff),
        .o_word      (w_nib_word),
        .o_last      (w_nib_last)
    );

    // Sequencer: next state and strobes.
    always_comb begin
        n_state       = r_state;
        w_emit        = 1'b0;
        w_load_init   = 1'b0;
        w_shadow_we   = 1'b0;
        w_shadow_word = w_nib_word;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_load_init = 1'b1;
                if (r_left == '0) begin
                    // Empty span: no beat, but the shadow still takes the old word.
                    w_shadow_we   = 1'b1;
                    w_shadow_word = w_init_word;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    w_emit = 1'b1;
                    if (w_nib_last) begin
                        w_shadow_we = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FG_COLOUR: r_fg <= i_cfg_data;
                CFG_BG_COLOUR: r_bg <= i_cfg_data;
                default:       r_fg <= r_fg;
            endcase
        end
    end

    // Shadow valid bits: clear on reset, set on every shadow write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_shadow_we) begin
            r_valid[r_row] <= 1'b1;
        end
    end

    // Output beat valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x        <= i_in.x_pos;
            r_row      <= i_in.row_index;
            r_left     <= SPAN_W'(w_width) + SPAN_W'(i_in.x_pos[1:0]);
            r_bits     <= {i_in.row_bits, {NIB_W{1'b0}}} >> i_in.x_pos[1:0];
            r_cell_end <= w_end_x[XPOS_W:2];
        end
        if (w_load_init) begin
            r_word  <= w_init_word;
            r_first <= 1'b1;
        end
        if (w_emit) begin
            r_word     <= w_nib_word;
            r_first    <= 1'b0;
            r_bits     <= r_bits << NIB_W;
            r_left     <= r_left - SPAN_W'(NIB_W);
            r_out_word <= w_nib_word;
            r_out_last <= w_nib_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_word = r_out_word;
    assign o_out.last_word  = r_out_last;

endmodule
`default_nettype wire
